### rtl/nads_pkg.sv
// Shared types and constants for the dispersion statistics core.
// Used by the arithmetic unit and the top level.
package nads_pkg;

    localparam int SAMPLE_W  = 32;
    localparam int VCOUNT_W  = 11;
    localparam int STATUS_W  = 6;
    localparam int PADDR_W   = 2;

    localparam logic [PADDR_W-1:0] ADDR_EPS  = 2'd0;
    localparam logic [30:0]        EPS_RESET = 31'd1;

    // status bit positions
    localparam int ST_NO_MEAN = 0;
    localparam int ST_NO_STD  = 1;
    localparam int ST_CV_UND  = 2;
    localparam int ST_CR_UND  = 3;
    localparam int ST_SR_UND  = 4;
    localparam int ST_OVF     = 5;

    typedef enum logic [1:0] {
        AR_DIV,
        AR_MUL,
        AR_SQRT
    } ar_op_t;

    typedef struct packed {
        logic   start;
        ar_op_t op;
    } ar_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ar_sts_t;

    // Apply sign to an unsigned quotient and saturate to 32-bit signed.
    function automatic logic [31:0] ratio_sat(input logic [32:0] q, input logic neg);
        logic [32:0] nq;
        nq = -q;
        if (neg) begin
            return (q > 33'h0_8000_0000) ? 32'h8000_0000 : nq[31:0];
        end
        return (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    endfunction

endpackage

### rtl/nads_arith.sv
// Shared iterative unit: restoring divide, shift-add multiply, integer square root.
// One bit (divide, multiply) or one root digit (square root) per cycle. Uses nads_pkg.
module nads_arith import nads_pkg::*; #(
    parameter int DVD_W = 86,
    parameter int DVS_W = 33
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  ar_ctl_t          ctl,
    input  logic [DVD_W-1:0] opa,
    input  logic [DVS_W-1:0] opb,
    output ar_sts_t          sts,
    output logic [DVD_W-1:0] result
);

    localparam int CW = $clog2(DVD_W + 1);

    ar_op_t           op_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [DVD_W-1:0] acc_reg;
    logic [DVD_W-1:0] aux_reg;
    logic [DVS_W-1:0] rem_reg;
    logic [DVS_W-1:0] dvs_reg;

    logic [DVS_W:0]   div_sh;
    logic [DVS_W:0]   div_diff;
    logic             div_ge;
    logic [CW-1:0]    sq_idx;
    logic [63:0]      sq_bit;
    logic [63:0]      sq_trial;
    logic             sq_ge;
    logic [DVD_W-1:0] mul_add;

    assign div_sh   = {rem_reg, aux_reg[DVD_W-1]};
    assign div_ge   = div_sh >= {1'b0, dvs_reg};
    assign div_diff = div_sh - {1'b0, dvs_reg};
    assign sq_idx   = cnt_reg - CW'(1);
    assign sq_bit   = 64'd1 << {sq_idx[4:0], 1'b0};
    assign sq_trial = aux_reg[63:0] + sq_bit;
    assign sq_ge    = acc_reg[63:0] >= sq_trial;
    assign mul_add  = acc_reg + (rem_reg[0] ? aux_reg : '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= AR_DIV;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl.start) begin
                op_reg   <= ctl.op;
                busy_reg <= 1'b1;
                unique case (ctl.op)
                    AR_DIV:  cnt_reg <= CW'(DVD_W);
                    AR_MUL:  cnt_reg <= CW'(DVS_W);
                    AR_SQRT: cnt_reg <= CW'(32);
                    default: cnt_reg <= CW'(1);
                endcase
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            unique case (ctl.op)
                AR_DIV: begin
                    aux_reg <= opa;
                    rem_reg <= '0;
                    dvs_reg <= opb;
                end
                AR_MUL: begin
                    acc_reg <= '0;
                    aux_reg <= opa;
                    rem_reg <= opb;
                end
                AR_SQRT: begin
                    acc_reg <= opa;
                    aux_reg <= '0;
                end
                default: begin
                    aux_reg <= '0;
                end
            endcase
        end else if (busy_reg) begin
            unique case (op_reg)
                AR_DIV: begin
                    rem_reg <= div_ge ? div_diff[DVS_W-1:0] : div_sh[DVS_W-1:0];
                    aux_reg <= {aux_reg[DVD_W-2:0], div_ge};
                end
                AR_MUL: begin
                    acc_reg <= mul_add;
                    aux_reg <= aux_reg << 1;
                    rem_reg <= rem_reg >> 1;
                end
                AR_SQRT: begin
                    if (sq_ge) begin
                        acc_reg <= DVD_W'(acc_reg[63:0] - sq_trial);
                        aux_reg <= DVD_W'((aux_reg[63:0] >> 1) + sq_bit);
                    end else begin
                        aux_reg <= aux_reg >> 1;
                    end
                end
                default: begin
                    aux_reg <= aux_reg;
                end
            endcase
        end
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign result   = (op_reg == AR_MUL) ? acc_reg : aux_reg;

endmodule

### rtl/nads_store.sv
// Sample store: one write port, one registered read port.
// Entry holds {missing mark, sample}. No package dependency.
module nads_store #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10,
    parameter int DW    = 33
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] store_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/nan_aware_dispersion_stats_core.sv
// Dispersion statistics core: loads a sample set, then runs the two-pass statistics.
// Depends on nads_pkg, nads_arith and nads_store.
//
//  channel | ports             | direction | content
//  --------+-------------------+-----------+-------------------------------------
//  input   | s_valid / s_ready | in        | sample, missing mark, last mark
//  result  | m_valid / m_ready | out       | max, min, mean, std, ratios, count, status
//  config  | psel .. pready    | in/out    | eps_threshold at byte address 0
//
// Loading takes one sample per cycle. After the last-marked transfer s_ready drops
// while the shared arith unit works through up to five bit-serial divides (over
// DVD_W = 64 + 2*CNT_W dividend bits), a multiply and a square root, and while the
// second pass runs over the store.
// The result sits in an output register; loading of the next set resumes at once.
// A new set cannot finish while the previous result is still untaken.
// Reset is synchronous; the store needs no clearing pass.
module nan_aware_dispersion_stats_core import nads_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int FRAC_BITS   = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [31:0]       s_sample,
    input  logic                     s_sample_is_nan,
    input  logic                     s_last,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [31:0]       m_max_value,
    output logic signed [31:0]       m_min_value,
    output logic signed [31:0]       m_mean_value,
    output logic [30:0]              m_std_value,
    output logic [30:0]              m_studentized,
    output logic signed [31:0]       m_coeff_variation,
    output logic signed [31:0]       m_coeff_range,
    output logic [VCOUNT_W-1:0]      m_valid_count,
    output logic [STATUS_W-1:0]      m_status_bits
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int AW    = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int SUM_W = SAMPLE_W + CNT_W;
    localparam int SQ_W  = 64 + CNT_W;
    localparam int DVD_W = 64 + 2 * CNT_W;
    localparam int DVS_W = (2 * CNT_W > 33) ? 2 * CNT_W : 33;

    typedef enum logic [4:0] {
        S_LOAD, S_MEAN, S_MEAN_W, S_NM, S_NM_W, S_RR, S_RR_W, S_NN, S_NN_W,
        S_PS, S_PASS, S_DRAIN, S_SCALE_W, S_VAR_W, S_SQRT_W, S_STUD_W,
        S_CV, S_CV_W, S_CR, S_CR_W, S_EMIT
    } state_t;

    state_t                  state_reg;
    logic [30:0]             eps_reg;
    logic [CNT_W-1:0]        stored_cnt_reg;
    logic [CNT_W-1:0]        good_cnt_reg;
    logic signed [31:0]      run_max_reg;
    logic signed [31:0]      run_min_reg;
    logic signed [SUM_W-1:0] run_sum_reg;
    logic                    ovf_reg;

    logic signed [31:0]      mean_reg;
    logic [63:0]             rr_reg;
    logic [DVS_W-1:0]        nn_reg;
    logic [SQ_W-1:0]         acc_reg;
    logic [30:0]             std_reg;
    logic [30:0]             stud_reg;
    logic [31:0]             cv_reg;
    logic [31:0]             cr_reg;
    logic [STATUS_W-1:0]     stat_reg;

    logic [31:0]             mul_a_reg;
    logic [31:0]             mul_b_reg;
    logic [63:0]             prod_reg;
    logic [CNT_W-1:0]        rd_cnt_reg;
    logic                    p1_reg;
    logic                    p2_reg;
    logic                    p3_reg;

    ar_ctl_t                 ar_ctl_reg;
    logic [DVD_W-1:0]        ar_a_reg;
    logic [DVS_W-1:0]        ar_b_reg;
    ar_sts_t                 ar_sts;
    logic [DVD_W-1:0]        ar_result;

    logic                    m_valid_reg;
    logic signed [31:0]      m_max_reg;
    logic signed [31:0]      m_min_reg;
    logic signed [31:0]      m_mean_reg;
    logic [30:0]             m_std_reg;
    logic [30:0]             m_stud_reg;
    logic [31:0]             m_cv_reg;
    logic [31:0]             m_cr_reg;
    logic [VCOUNT_W-1:0]     m_cnt_reg;
    logic [STATUS_W-1:0]     m_stat_reg;

    logic                    in_fire;
    logic                    cfg_wr;
    logic                    mem_we;
    logic                    rd_en;
    logic [32:0]             rd_data;

    logic                    sum_neg;
    logic [SUM_W-1:0]        sum_mag;
    logic                    mean_neg;
    logic [31:0]             mean_mag;
    logic [32:0]             range_w;
    logic [31:0]             range_u;
    logic signed [32:0]      mid_w;
    logic                    mid_neg;
    logic [32:0]             mid_mag;
    logic [SUM_W-1:0]        r_w;
    logic [SUM_W-1:0]        r_mag;
    logic [32:0]             d_w;
    logic [31:0]             dm;
    logic [32:0]             q_clip;
    logic [63:0]             var64;
    logic [30:0]             std_c;
    logic [31:0]             rs_pos;
    logic [31:0]             rs_cv;
    logic [31:0]             rs_cr;
    logic [CNT_W-1:0]        n;

    assign n        = good_cnt_reg;
    assign in_fire  = s_valid && s_ready;
    assign s_ready  = (state_reg == S_LOAD);
    assign mem_we   = in_fire && (stored_cnt_reg < CNT_W'(MAX_SAMPLES));
    assign rd_en    = (state_reg == S_PASS) && (rd_cnt_reg < stored_cnt_reg);
    assign cfg_wr   = psel && penable && pwrite && (paddr == ADDR_EPS);

    assign pready   = 1'b1;
    assign prdata   = (paddr == ADDR_EPS) ? {1'b0, eps_reg} : 32'd0;

    assign sum_neg  = run_sum_reg[SUM_W-1];
    assign sum_mag  = sum_neg ? SUM_W'(-run_sum_reg) : SUM_W'(run_sum_reg);
    assign mean_neg = mean_reg[31];
    assign mean_mag = mean_neg ? 32'(-mean_reg) : 32'(mean_reg);
    assign range_w  = {run_max_reg[31], run_max_reg} - {run_min_reg[31], run_min_reg};
    assign range_u  = range_w[31:0];
    assign mid_w    = {run_max_reg[31], run_max_reg} + {run_min_reg[31], run_min_reg};
    assign mid_neg  = mid_w[32];
    assign mid_mag  = mid_neg ? 33'(-mid_w) : 33'(mid_w);

    // residual of the rounded mean: sum - n*mean
    assign r_w      = mean_neg ? SUM_W'(run_sum_reg) + prod_reg[SUM_W-1:0]
                               : SUM_W'(run_sum_reg) - prod_reg[SUM_W-1:0];
    assign r_mag    = r_w[SUM_W-1] ? -r_w : r_w;

    assign d_w      = {rd_data[31], rd_data[31:0]} - {mean_reg[31], mean_reg};
    assign dm       = d_w[32] ? 32'(-d_w) : d_w[31:0];

    assign q_clip   = (|ar_result[DVD_W-1:33]) ? '1 : ar_result[32:0];
    assign var64    = (|ar_result[DVD_W-1:64]) ? '1 : ar_result[63:0];
    assign std_c    = ar_result[31] ? '1 : ar_result[30:0];
    assign rs_pos   = ratio_sat(q_clip, 1'b0);
    assign rs_cv    = ratio_sat(q_clip, mean_neg);
    assign rs_cr    = ratio_sat(q_clip, mid_neg);

    nads_store #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW),
        .DW    (33)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (stored_cnt_reg[AW-1:0]),
        .wr_data ({s_sample_is_nan, s_sample}),
        .rd_en   (rd_en),
        .rd_addr (rd_cnt_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    nads_arith #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ar_ctl_reg),
        .opa     (ar_a_reg),
        .opb     (ar_b_reg),
        .sts     (ar_sts),
        .result  (ar_result)
    );

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(mul_a_reg) * 64'(mul_b_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            eps_reg        <= EPS_RESET;
            stored_cnt_reg <= '0;
            good_cnt_reg   <= '0;
            run_max_reg    <= 32'sh8000_0000;
            run_min_reg    <= 32'sh7FFF_FFFF;
            run_sum_reg    <= '0;
            ovf_reg        <= 1'b0;
            ar_ctl_reg     <= '0;
            p1_reg         <= 1'b0;
            p2_reg         <= 1'b0;
            p3_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            // start is a one-cycle pulse; no new start is issued right after one
            if (ar_ctl_reg.start) begin
                ar_ctl_reg.start <= 1'b0;
            end
            if (cfg_wr) begin
                eps_reg <= pwdata[30:0];
            end
            if (m_valid_reg && m_ready && (state_reg != S_EMIT)) begin
                m_valid_reg <= 1'b0;
            end

            // second-pass pipeline: read -> deviation square -> accumulate
            p1_reg <= rd_en;
            p2_reg <= p1_reg && !rd_data[32];
            p3_reg <= p2_reg;
            if (p1_reg) begin
                mul_a_reg <= dm;
                mul_b_reg <= dm;
            end
            if (p3_reg) begin
                acc_reg <= acc_reg + SQ_W'(prod_reg);
            end

            unique case (state_reg)
                S_LOAD: begin
                    if (in_fire) begin
                        if (mem_we) begin
                            stored_cnt_reg <= stored_cnt_reg + CNT_W'(1);
                            if (!s_sample_is_nan) begin
                                if (s_sample > run_max_reg) run_max_reg <= s_sample;
                                if (s_sample < run_min_reg) run_min_reg <= s_sample;
                                run_sum_reg  <= run_sum_reg + SUM_W'(s_sample);
                                good_cnt_reg <= good_cnt_reg + CNT_W'(1);
                            end
                        end else begin
                            ovf_reg <= 1'b1;
                        end
                        if (s_last) begin
                            state_reg <= S_MEAN;
                        end
                    end
                end
                S_MEAN: begin
                    mean_reg <= '0;
                    std_reg  <= '0;
                    stud_reg <= '0;
                    cv_reg   <= '0;
                    cr_reg   <= '0;
                    if (n == '0) begin
                        stat_reg <= STATUS_W'(1 << ST_NO_MEAN) | STATUS_W'(1 << ST_NO_STD) |
                                    STATUS_W'(1 << ST_CV_UND)  | STATUS_W'(1 << ST_CR_UND) |
                                    STATUS_W'(1 << ST_SR_UND);
                        state_reg <= S_EMIT;
                    end else begin
                        stat_reg   <= '0;
                        ar_ctl_reg <= '{start: 1'b1, op: AR_DIV};
                        ar_a_reg   <= DVD_W'(sum_mag + SUM_W'(n >> 1));
                        ar_b_reg   <= DVS_W'(n);
                        state_reg  <= S_MEAN_W;
                    end
                end
                S_MEAN_W: begin
                    if (ar_sts.done) begin
                        mean_reg <= sum_neg ? 32'(-q_clip) : q_clip[31:0];
                        if (n >= CNT_W'(2)) begin
                            state_reg <= S_NM;
                        end else begin
                            stat_reg[ST_NO_STD] <= 1'b1;
                            stat_reg[ST_CV_UND] <= 1'b1;
                            stat_reg[ST_SR_UND] <= 1'b1;
                            state_reg <= S_CR;
                        end
                    end
                end
                S_NM: begin
                    mul_a_reg <= 32'(n);
                    mul_b_reg <= mean_mag;
                    state_reg <= S_NM_W;
                end
                S_NM_W: state_reg <= S_RR;
                S_RR: begin
                    mul_a_reg <= r_mag[31:0];
                    mul_b_reg <= r_mag[31:0];
                    state_reg <= S_RR_W;
                end
                S_RR_W: state_reg <= S_NN;
                S_NN: begin
                    rr_reg    <= prod_reg;
                    mul_a_reg <= 32'(n);
                    mul_b_reg <= 32'(n - CNT_W'(1));
                    state_reg <= S_NN_W;
                end
                S_NN_W: state_reg <= S_PS;
                S_PS: begin
                    nn_reg     <= prod_reg[DVS_W-1:0];
                    acc_reg    <= '0;
                    rd_cnt_reg <= '0;
                    state_reg  <= S_PASS;
                end
                S_PASS: begin
                    if (rd_en) begin
                        rd_cnt_reg <= rd_cnt_reg + CNT_W'(1);
                    end else begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!p1_reg && !p2_reg && !p3_reg) begin
                        ar_ctl_reg <= '{start: 1'b1, op: AR_MUL};
                        ar_a_reg   <= DVD_W'(acc_reg);
                        ar_b_reg   <= DVS_W'(n);
                        state_reg  <= S_SCALE_W;
                    end
                end
                S_SCALE_W: begin
                    if (ar_sts.done) begin
                        ar_ctl_reg <= '{start: 1'b1, op: AR_DIV};
                        ar_a_reg   <= ar_result - DVD_W'(rr_reg);
                        ar_b_reg   <= nn_reg;
                        state_reg  <= S_VAR_W;
                    end
                end
                S_VAR_W: begin
                    if (ar_sts.done) begin
                        ar_ctl_reg <= '{start: 1'b1, op: AR_SQRT};
                        ar_a_reg   <= DVD_W'(var64);
                        state_reg  <= S_SQRT_W;
                    end
                end
                S_SQRT_W: begin
                    if (ar_sts.done) begin
                        std_reg <= std_c;
                        if (std_c <= eps_reg) begin
                            stat_reg[ST_SR_UND] <= 1'b1;
                            state_reg <= S_CV;
                        end else begin
                            ar_ctl_reg <= '{start: 1'b1, op: AR_DIV};
                            ar_a_reg   <= DVD_W'(range_u) << FRAC_BITS;
                            ar_b_reg   <= DVS_W'(std_c);
                            state_reg  <= S_STUD_W;
                        end
                    end
                end
                S_STUD_W: begin
                    if (ar_sts.done) begin
                        stud_reg  <= rs_pos[30:0];
                        state_reg <= S_CV;
                    end
                end
                S_CV: begin
                    if (mean_mag <= 32'(eps_reg)) begin
                        stat_reg[ST_CV_UND] <= 1'b1;
                        state_reg <= S_CR;
                    end else begin
                        ar_ctl_reg <= '{start: 1'b1, op: AR_DIV};
                        ar_a_reg   <= DVD_W'(std_reg) << FRAC_BITS;
                        ar_b_reg   <= DVS_W'(mean_mag);
                        state_reg  <= S_CV_W;
                    end
                end
                S_CV_W: begin
                    if (ar_sts.done) begin
                        cv_reg    <= rs_cv;
                        state_reg <= S_CR;
                    end
                end
                S_CR: begin
                    if (mid_mag <= 33'(eps_reg)) begin
                        stat_reg[ST_CR_UND] <= 1'b1;
                        state_reg <= S_EMIT;
                    end else begin
                        ar_ctl_reg <= '{start: 1'b1, op: AR_DIV};
                        ar_a_reg   <= DVD_W'(range_u) << FRAC_BITS;
                        ar_b_reg   <= DVS_W'(mid_mag);
                        state_reg  <= S_CR_W;
                    end
                end
                S_CR_W: begin
                    if (ar_sts.done) begin
                        cr_reg    <= rs_cr;
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg    <= 1'b1;
                        m_max_reg      <= run_max_reg;
                        m_min_reg      <= run_min_reg;
                        m_mean_reg     <= mean_reg;
                        m_std_reg      <= std_reg;
                        m_stud_reg     <= stud_reg;
                        m_cv_reg       <= cv_reg;
                        m_cr_reg       <= cr_reg;
                        m_cnt_reg      <= VCOUNT_W'(n);
                        m_stat_reg     <= stat_reg | (STATUS_W'(ovf_reg) << ST_OVF);
                        stored_cnt_reg <= '0;
                        good_cnt_reg   <= '0;
                        run_max_reg    <= 32'sh8000_0000;
                        run_min_reg    <= 32'sh7FFF_FFFF;
                        run_sum_reg    <= '0;
                        ovf_reg        <= 1'b0;
                        state_reg      <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_max_value       = m_max_reg;
    assign m_min_value       = m_min_reg;
    assign m_mean_value      = m_mean_reg;
    assign m_std_value       = m_std_reg;
    assign m_studentized     = m_stud_reg;
    assign m_coeff_variation = m_cv_reg;
    assign m_coeff_range     = m_cr_reg;
    assign m_valid_count     = m_cnt_reg;
    assign m_status_bits     = m_stat_reg;

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ar_ctl_reg.start |-> !ar_sts.busy)
        else $error("arith unit started while busy");

    a_store_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (stored_cnt_reg < CNT_W'(MAX_SAMPLES)))
        else $error("store written past its depth");

    a_emit_only: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside emit");

    a_count_order: assert property (@(posedge aclk) disable iff (!aresetn)
        good_cnt_reg <= stored_cnt_reg)
        else $error("valid count exceeds stored count");

endmodule
